/* rtl/csb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package csb_pkg;

	// bank size and derived index width
	localparam int NUM_SLOTS = 64;
	localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W     = 16;

	// command codes
	localparam logic [2:0] CMD_OPEN  = 3'd0;
	localparam logic [2:0] CMD_CLOSE = 3'd1;
	localparam logic [2:0] CMD_UP    = 3'd2;
	localparam logic [2:0] CMD_DOWN  = 3'd3;
	localparam logic [2:0] CMD_ALLOC = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_ERR   = 2'd1;
	localparam logic [1:0] ST_BLOCK = 2'd2;

	// count markers
	localparam logic [CNT_W-1:0] CLOSED_CNT = 16'hFFFF;
	localparam logic [CNT_W-1:0] CNT_MAX    = 16'h7FFF;

	typedef struct packed {
		logic [2:0]        cmd;
		logic [7:0]        sem_index;
		logic signed [15:0] init_value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [5:0]         slot_out;
		logic               wake;
		logic signed [15:0] count_after;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_hold;
	} dp_stat_t;

endpackage

`default_nettype wire

/* rtl/csb_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module csb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* rtl/csb_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module csb_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_ready,
	output csb_pkg::ctrl_cmd_t        cmd,
	input  wire csb_pkg::dp_stat_t    stat
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   ready_q;

	// take an item in idle, finish it once the result register is free
	always_comb begin
		cmd.load = req_valid && ready_q;
		cmd.exec = (state_q == S_EXEC) && !stat.out_hold;
	end

	assign req_ready = ready_q;

	// state and registered ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid && ready_q) begin
						state_q <= S_EXEC;
						ready_q <= 1'b0;
					end
				end
				S_EXEC: begin
					if (!stat.out_hold) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/csb_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module csb_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire csb_pkg::req_t        req,
	input  wire csb_pkg::ctrl_cmd_t   cmd,
	output csb_pkg::dp_stat_t         stat,
	output logic                      rsp_valid,
	input  wire logic                 rsp_ready,
	output csb_pkg::rsp_t             rsp
);

	localparam int SW = csb_pkg::SLOT_W;
	localparam int CW = csb_pkg::CNT_W;

	csb_pkg::req_t        req_q;
	logic                 active_q [csb_pkg::NUM_SLOTS];
	logic [SW-1:0]        free_idx;
	logic                 free_ok;
	logic [SW-1:0]        free_q;
	logic                 free_ok_q;
	csb_pkg::rsp_t        rsp_q;
	logic                 rsp_valid_q;

	logic [CW-1:0]        rd_data;
	logic                 wr_en;
	logic [SW-1:0]        wr_addr;
	logic [CW-1:0]        wr_data;

	logic [SW-1:0]        slot;
	logic                 in_range;
	logic                 act;
	logic [CW-1:0]        cur;
	logic [CW-1:0]        ival;
	logic                 ival_neg;
	logic                 set_act;
	logic                 clr_act;
	logic [SW-1:0]        act_addr;
	csb_pkg::rsp_t        res;

	// count store
	csb_ram #(
		.WIDTH (CW),
		.DEPTH (csb_pkg::NUM_SLOTS)
	) u_cnt_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (cmd.load),
		.rd_addr (req.sem_index[SW-1:0]),
		.rd_data (rd_data)
	);

	// request register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	// lowest free slot, registered each cycle
	always_comb begin
		free_idx = '0;
		free_ok  = 1'b0;
		for (int i = csb_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_idx = SW'(i);
				free_ok  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q    <= '0;
			free_ok_q <= 1'b0;
		end else begin
			free_q    <= free_idx;
			free_ok_q <= free_ok;
		end
	end

	// command evaluation on the slot read back
	always_comb begin
		slot     = req_q.sem_index[SW-1:0];
		in_range = {1'b0, req_q.sem_index} < 9'(csb_pkg::NUM_SLOTS);
		act      = active_q[slot];
		cur      = act ? rd_data : csb_pkg::CLOSED_CNT;
		ival     = $unsigned(req_q.init_value);
		ival_neg = ival[CW-1];

		res.status      = csb_pkg::ST_ERR;
		res.slot_out    = req_q.sem_index[5:0];
		res.wake        = 1'b0;
		res.count_after = $signed(csb_pkg::CLOSED_CNT);
		wr_en    = 1'b0;
		wr_addr  = slot;
		wr_data  = ival;
		set_act  = 1'b0;
		clr_act  = 1'b0;
		act_addr = slot;

		if (req_q.cmd == csb_pkg::CMD_ALLOC) begin
			res.slot_out = '0;
			if (free_ok_q && !ival_neg) begin
				set_act         = 1'b1;
				act_addr        = free_q;
				wr_en           = 1'b1;
				wr_addr         = free_q;
				res.slot_out    = 6'(free_q);
				res.count_after = $signed(ival);
				res.status      = csb_pkg::ST_OK;
			end
		end else if (in_range) begin
			res.count_after = $signed(cur);
			case (req_q.cmd)
				csb_pkg::CMD_OPEN: begin
					if (!act && !ival_neg) begin
						set_act         = 1'b1;
						wr_en           = 1'b1;
						res.count_after = $signed(ival);
						res.status      = csb_pkg::ST_OK;
					end
				end
				csb_pkg::CMD_CLOSE: begin
					if (act) begin
						clr_act         = 1'b1;
						res.count_after = $signed(csb_pkg::CLOSED_CNT);
						res.wake        = 1'b1;
						res.status      = csb_pkg::ST_OK;
					end
				end
				csb_pkg::CMD_UP: begin
					if (act && (cur < csb_pkg::CNT_MAX)) begin
						wr_en           = 1'b1;
						wr_data         = cur + 16'd1;
						res.count_after = $signed(cur + 16'd1);
						res.wake        = (cur == '0);
						res.status      = csb_pkg::ST_OK;
					end
				end
				csb_pkg::CMD_DOWN: begin
					if (act) begin
						if (cur == '0) begin
							res.status = csb_pkg::ST_BLOCK;
						end else begin
							wr_en           = 1'b1;
							wr_data         = cur - 16'd1;
							res.count_after = $signed(cur - 16'd1);
							res.status      = csb_pkg::ST_OK;
						end
					end
				end
				default: begin
				end
			endcase
		end

		if (!cmd.exec) begin
			wr_en   = 1'b0;
			set_act = 1'b0;
			clr_act = 1'b0;
		end
	end

	// active bits, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < csb_pkg::NUM_SLOTS; i++) begin
				active_q[i] <= 1'b0;
			end
		end else begin
			if (set_act) begin
				active_q[act_addr] <= 1'b1;
			end else if (clr_act) begin
				active_q[act_addr] <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rsp_q <= res;
		end
	end

	assign stat.out_hold = rsp_valid_q && !rsp_ready;
	assign rsp_valid     = rsp_valid_q;
	assign rsp           = rsp_q;

endmodule

`default_nettype wire

/* rtl/counting_semaphore_bank.sv */
// sequence: an item's slot is read from the count RAM on acceptance, and
//   its count is written back when the result register loads; one item at a
//   time, req_ready stays low until the result is registered
// reset: arst_n clears all active bits and the result valid flag; counts of
//   inactive slots read as -1, so the count RAM needs no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module counting_semaphore_bank (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire csb_pkg::req_t  req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output csb_pkg::rsp_t       rsp
);

	csb_pkg::ctrl_cmd_t cmd;
	csb_pkg::dp_stat_t  stat;

	// sequencer
	csb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// slot state and result
	csb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

/* sim/csb_checker.sv */
`timescale 1ns / 1ps

module csb_checker
	import csb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp,
	output int   mismatches,
	output int   outstanding,
	output int   n_ok,
	output int   n_err,
	output int   n_block,
	output int   n_wake
);

	// shadow copy of the semaphore bank
	logic              slot_live [NUM_SLOTS];
	logic [CNT_W-1:0]  slot_cnt  [NUM_SLOTS];

	// responses predicted but not yet seen on the output
	rsp_t due_rsp [$];

	int fails;
	int seen_ok, seen_err, seen_block, seen_wake;
	int rsp_seq;

	// apply one request to the shadow bank and return the response it should give
	function automatic rsp_t predict_sem_rsp(input req_t r);
		rsp_t             o;
		int               free_slot;
		logic             live;
		logic [CNT_W-1:0] cur;
		o.status      = ST_ERR;
		o.slot_out    = r.sem_index[5:0];
		o.wake        = 1'b0;
		o.count_after = CLOSED_CNT;
		if (r.cmd == CMD_ALLOC) begin
			o.slot_out = '0;
			free_slot  = -1;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (!slot_live[i] && free_slot < 0) begin
					free_slot = i;
				end
			end
			if (free_slot >= 0 && !r.init_value[15]) begin
				slot_live[free_slot] = 1'b1;
				slot_cnt[free_slot]  = r.init_value;
				o.slot_out           = free_slot[5:0];
				o.count_after        = r.init_value;
				o.status             = ST_OK;
			end
		end else if (r.sem_index < NUM_SLOTS) begin
			live          = slot_live[r.sem_index];
			cur           = slot_cnt[r.sem_index];
			o.count_after = cur;
			case (r.cmd)
				CMD_OPEN: begin
					if (!live && !r.init_value[15]) begin
						slot_live[r.sem_index] = 1'b1;
						slot_cnt[r.sem_index]  = r.init_value;
						o.count_after          = r.init_value;
						o.status               = ST_OK;
					end
				end
				CMD_CLOSE: begin
					if (live) begin
						slot_live[r.sem_index] = 1'b0;
						slot_cnt[r.sem_index]  = CLOSED_CNT;
						o.count_after          = CLOSED_CNT;
						o.wake                 = 1'b1;
						o.status               = ST_OK;
					end
				end
				CMD_UP: begin
					if (live && cur < CNT_MAX) begin
						slot_cnt[r.sem_index] = cur + 1'b1;
						o.count_after         = cur + 1'b1;
						o.wake                = (cur == '0);
						o.status              = ST_OK;
					end
				end
				CMD_DOWN: begin
					if (live) begin
						if (cur == '0) begin
							o.status = ST_BLOCK;
						end else begin
							slot_cnt[r.sem_index] = cur - 1'b1;
							o.count_after         = cur - 1'b1;
							o.status              = ST_OK;
						end
					end
				end
				default: begin
				end
			endcase
		end
		return o;
	endfunction

	// watch both channels: retire the oldest prediction, then queue the new one
	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		logic bad;
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_live[i] = 1'b0;
				slot_cnt[i]  = CLOSED_CNT;
			end
			due_rsp.delete();
			fails      = 0;
			seen_ok    = 0;
			seen_err   = 0;
			seen_block = 0;
			seen_wake  = 0;
			rsp_seq    = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (due_rsp.size() == 0) begin
					fails++;
					if (fails <= 10) begin
						$display("unexpected result %0d: status %0d slot %0d wake %0d count %0d",
							rsp_seq, rsp.status, rsp.slot_out, rsp.wake, rsp.count_after);
					end
				end else begin
					want = due_rsp.pop_front();
					bad  = (rsp.status != want.status) || (rsp.slot_out != want.slot_out) ||
						(rsp.wake != want.wake) || (rsp.count_after != want.count_after);
					if (bad) begin
						fails++;
						if (fails <= 10) begin
							$display("mismatch on result %0d: want st %0d slot %0d wake %0d cnt %0d",
								rsp_seq, want.status, want.slot_out, want.wake, want.count_after);
							$display("                     got  st %0d slot %0d wake %0d cnt %0d",
								rsp.status, rsp.slot_out, rsp.wake, rsp.count_after);
						end
					end
					case (want.status)
						ST_OK:    seen_ok++;
						ST_BLOCK: seen_block++;
						default:  seen_err++;
					endcase
					if (want.wake) begin
						seen_wake++;
					end
				end
				rsp_seq++;
			end
			if (req_valid && req_ready) begin
				due_rsp.push_back(predict_sem_rsp(req));
			end
		end
		mismatches  <= fails;
		outstanding <= due_rsp.size();
		n_ok        <= seen_ok;
		n_err       <= seen_err;
		n_block     <= seen_block;
		n_wake      <= seen_wake;
	end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import csb_pkg::*;

	localparam int RANDOM_ITEMS  = 1650;
	localparam int HOLD_CYCLES   = 200;
	localparam int STALL_LIMIT   = 4000;
	localparam int TAIL_CYCLES   = 8;

	// command codes the block does not define
	localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	bit hold_rsp   = 1'b0;
	int burst_left = 0;
	int n_sent     = 0;

	int mismatches, outstanding, n_ok, n_err, n_block, n_wake;

	counting_semaphore_bank u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	csb_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.n_ok        (n_ok),
		.n_err       (n_err),
		.n_block     (n_block),
		.n_wake      (n_wake)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic req_t mk(input logic [2:0] cmd, input logic [7:0] idx,
		input logic signed [15:0] init);
		req_t r;
		r.cmd        = cmd;
		r.sem_index  = idx;
		r.init_value = init;
		return r;
	endfunction

	// initial counts, biased toward the edges of the range
	function automatic logic signed [15:0] pick_init();
		case ($urandom_range(0, 9))
			0:       return 16'sd0;
			1:       return 16'sd1;
			2:       return 16'sh7FFF;
			3:       return 16'sh7FFE;
			4, 5:    return 16'($urandom_range(0, 5));
			6:       return 16'($urandom_range(0, 32767));
			7:       return 16'($urandom);
			default: return -16'($urandom_range(1, 32768));
		endcase
	endfunction

	// gaps between bursts; none while the response side is held off
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end
		if (burst_left == 0 && !hold_rsp) begin
			gap        = $urandom_range(1, 12);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
				: $urandom_range(1, 24);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// offer one item and hold it until accepted
	task automatic issue(input req_t r);
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		n_sent++;
		pace();
	endtask

	// churn a window of eight slots with mixed commands
	task automatic churn_window();
		int         base;
		int         pick;
		logic [2:0] cmd;
		logic [7:0] idx;
		base = $urandom_range(0, NUM_SLOTS - 8);
		repeat ($urandom_range(20, 40)) begin
			pick = $urandom_range(0, 99);
			if (pick < 15)      cmd = CMD_OPEN;
			else if (pick < 25) cmd = CMD_CLOSE;
			else if (pick < 55) cmd = CMD_UP;
			else if (pick < 85) cmd = CMD_DOWN;
			else if (pick < 93) cmd = CMD_ALLOC;
			else                cmd = CMD_UNUSED_FIRST + 3'($urandom_range(0, 2));
			idx = 8'(base + $urandom_range(0, 7));
			if ($urandom_range(0, 24) == 0) begin
				idx = 8'($urandom_range(NUM_SLOTS, 255));
			end
			issue(mk(cmd, idx, pick_init()));
		end
	endtask

	// drive one counter toward zero or toward the top
	task automatic run_counter();
		logic [7:0]         s;
		logic signed [15:0] start;
		int                 up_pct;
		s = 8'($urandom_range(0, NUM_SLOTS - 1));
		case ($urandom_range(0, 3))
			0:       start = 16'sd0;
			1:       start = 16'sd2;
			2:       start = 16'sh7FFD;
			default: start = 16'($urandom_range(0, 32767));
		endcase
		up_pct = (start > 16'sd100) ? 80 : 25;
		issue(mk(CMD_OPEN, s, start));
		repeat ($urandom_range(8, 24)) begin
			issue(mk(($urandom_range(0, 99) < up_pct) ? CMD_UP : CMD_DOWN, s, pick_init()));
		end
		if ($urandom_range(0, 1) == 0) begin
			issue(mk(CMD_CLOSE, s, pick_init()));
		end
	endtask

	// fill the whole bank by allocation, overrun it, then close most slots
	task automatic fill_and_sweep();
		repeat (NUM_SLOTS + 3) begin
			issue(mk(CMD_ALLOC, 8'($urandom), 16'($urandom_range(0, 32767))));
		end
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if ($urandom_range(0, 3) != 0) begin
				issue(mk(CMD_CLOSE, 8'(i), 16'($urandom)));
			end
		end
	endtask

	// fully random items, unused commands and wild indices included
	task automatic noise();
		repeat ($urandom_range(8, 20)) begin
			issue(mk(3'($urandom_range(0, 7)), 8'($urandom), 16'($urandom)));
		end
	endtask

	// response side: a changing stall pattern, plus one long hold-off on request
	initial begin : rsp_sink
		int mode, left, phase;
		mode  = 0;
		left  = 64;
		phase = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rsp = 1'b0;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(32, 256);
				end
				left--;
				phase++;
				case (mode)
					0:       rsp_ready <= 1'b1;
					1:       rsp_ready <= ($urandom_range(0, 99) < 60);
					2:       rsp_ready <= (phase % 4 == 0);
					default: rsp_ready <= ($urandom_range(0, 99) < 15);
				endcase
			end
		end
	end

	// end the run if neither channel moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
		$display("[counting_semaphore_bank] ERROR");
		$finish;
	end

	initial begin : stimulus
		int kind;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: blocking down, wake on up from zero, overflow, reopen,
		// negative init, double close, inactive slots, range and unused codes
		issue(mk(CMD_OPEN, 8'd0, 16'sd0));
		issue(mk(CMD_DOWN, 8'd0, 16'sd0));
		issue(mk(CMD_UP, 8'd0, 16'sd0));
		issue(mk(CMD_UP, 8'd0, 16'sd0));
		issue(mk(CMD_DOWN, 8'd0, 16'sd0));
		issue(mk(CMD_OPEN, 8'd63, 16'sh7FFF));
		issue(mk(CMD_UP, 8'd63, 16'sd0));
		issue(mk(CMD_OPEN, 8'd63, 16'sd5));
		issue(mk(CMD_DOWN, 8'd63, 16'sd0));
		issue(mk(CMD_OPEN, 8'd1, 16'sh8000));
		issue(mk(CMD_CLOSE, 8'd0, 16'sd0));
		issue(mk(CMD_CLOSE, 8'd0, 16'sd0));
		issue(mk(CMD_UP, 8'd5, 16'sd0));
		issue(mk(CMD_DOWN, 8'd5, 16'sd0));
		issue(mk(CMD_OPEN, 8'd255, 16'sd3));
		issue(mk(CMD_UP, 8'd64, 16'sd0));
		issue(mk(CMD_ALLOC, 8'd200, 16'sd7));
		issue(mk(CMD_ALLOC, 8'd0, -16'sd1));
		issue(mk(CMD_ALLOC, 8'd0, 16'sd0));
		issue(mk(CMD_UNUSED_FIRST, 8'd63, 16'sd0));
		issue(mk(CMD_UNUSED_FIRST + 3'd1, 8'd1, 16'sh7FFF));
		issue(mk(CMD_UNUSED_LAST, 8'd128, 16'sh8000));
		issue(mk(CMD_CLOSE, 8'd63, 16'sd0));

		// long response stall while requests keep coming
		hold_rsp = 1'b1;
		churn_window();

		while (n_sent < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 19);
			if (kind < 10)      churn_window();
			else if (kind < 14) run_counter();
			else if (kind < 17) noise();
			else                fill_and_sweep();
		end
		req_valid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("sent %0d requests: %0d ok, %0d error, %0d would-block, %0d wakes",
			n_sent, n_ok, n_err, n_block, n_wake);
		$display("covered full-bank allocation, count limits, bad codes and a long output stall");
		if (mismatches == 0 && outstanding == 0) begin
			$display("[counting_semaphore_bank] OK");
		end else begin
			$display("[counting_semaphore_bank] ERROR");
		end
		$finish;
	end

endmodule
